// ===== design/addressed_light_switch_controller_core_assert.svh =====
// assertion macros for the light switch controller checker
`ifndef ADDRESSED_LIGHT_SWITCH_CONTROLLER_CORE_ASSERT_SVH
`define ADDRESSED_LIGHT_SWITCH_CONTROLLER_CORE_ASSERT_SVH

// same-cycle implication
`define ALSC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("alsc assertion failed");

// next-cycle implication
`define ALSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("alsc assertion failed");

`endif

// ===== design/alsc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package alsc_pkg;

	localparam int SWITCH_COUNT = 6;
	localparam int SPECIAL_PIN = 6;
	localparam int BLOCK_SPECIAL = 6;
	localparam int BLOCK_DIM_DOWN = 8;
	localparam int BLOCK_DIM_UP = 9;

	localparam logic [5:0] DIM_MAX = 6'h3f;
	localparam logic [5:0] DEVICE_ID_RESET = 6'h01;
	localparam logic [5:0] REPLY_NONE = 6'd0;
	localparam logic [5:0] REPLY_YES = 6'd1;
	localparam logic [5:0] REPLY_NO = 6'd2;

	localparam logic ITEM_BYTE = 1'b0;
	localparam logic ITEM_TICK = 1'b1;

	localparam logic [5:0] CMD_READ_LINE = 6'h01;
	localparam logic [5:0] CMD_LINE_ON = 6'h02;
	localparam logic [5:0] CMD_LINE_OFF = 6'h03;
	localparam logic [5:0] CMD_READ_BLOCK = 6'h04;
	localparam logic [5:0] CMD_SET_BLOCK = 6'h05;
	localparam logic [5:0] CMD_CLR_BLOCK = 6'h06;
	localparam logic [5:0] CMD_SET_DIM = 6'h07;
	localparam logic [5:0] CMD_READ_DIM = 6'h08;
	localparam logic [5:0] CMD_LINE_TOGGLE = 6'h09;

	typedef enum logic [1:0] {
		HEAD_DEVICE = 2'b00,
		HEAD_LINE = 2'b01,
		HEAD_COMMAND = 2'b10,
		HEAD_REPLY = 2'b11
	} head_t;

	typedef enum logic [1:0] {
		FRM_IDLE = 2'd0,
		FRM_ADDRESSED = 2'd1,
		FRM_LINE = 2'd2
	} frame_t;

	typedef struct packed {
		logic cmd;
		logic [7:0] rx_byte;
		logic [7:0] switch_pins;
		logic dim_down_n;
		logic dim_up_n;
	} item_t;

	typedef struct packed {
		logic reply_valid;
		logic [5:0] reply_byte;
		logic [7:0] lines;
		logic [5:0] dim_level;
		logic dim_down_enable;
		logic dim_up_enable;
		logic special_send;
	} result_t;

	// lines 1..16 map to bits 0..15, anything else names no bit
	function automatic logic [15:0] line_mask(input logic [5:0] n);
		logic [15:0] m;
		m = 16'd0;
		if (n >= 6'd1 && n <= 6'd16) begin
			m = 16'd1 << (n - 6'd1);
		end
		return m;
	endfunction

endpackage
`default_nettype wire

// ===== design/addressed_light_switch_controller_core.sv =====
// an accepted item is held in the input register; its result enters the result register once that register can advance
// throughput: one item per cycle while out_stall is low, set by the single state update between the
//   input register and the result register
// reset: arst_n clears framer, line, block, dim and pin history; device id becomes 1
`timescale 1ns / 1ps
`default_nettype none
module addressed_light_switch_controller_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_wr_en,
	input wire logic [5:0] cfg_wr_data,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic cmd,
	input wire logic [7:0] rx_byte,
	input wire logic [7:0] switch_pins,
	input wire logic dim_down_n,
	input wire logic dim_up_n,
	output logic out_valid,
	input wire logic out_stall,
	output logic reply_valid,
	output logic [5:0] reply_byte,
	output logic [7:0] lines,
	output logic [5:0] dim_level,
	output logic dim_down_enable,
	output logic dim_up_enable,
	output logic special_send
);
	import alsc_pkg::*;

	item_t in_item;
	item_t item_s1;
	logic valid_s1;
	logic advance;
	result_t res_s2;

	assign in_item = '{cmd: cmd, rx_byte: rx_byte, switch_pins: switch_pins,
		dim_down_n: dim_down_n, dim_up_n: dim_up_n};

	alsc_in_reg u_in_reg (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.advance(advance),
		.valid_s1(valid_s1),
		.item_s1(item_s1)
	);

	alsc_proc u_proc (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.valid_s1(valid_s1),
		.item_s1(item_s1),
		.advance(advance),
		.out_stall(out_stall),
		.out_valid_s2(out_valid),
		.res_s2(res_s2)
	);

	assign reply_valid = res_s2.reply_valid;
	assign reply_byte = res_s2.reply_byte;
	assign lines = res_s2.lines;
	assign dim_level = res_s2.dim_level;
	assign dim_down_enable = res_s2.dim_down_enable;
	assign dim_up_enable = res_s2.dim_up_enable;
	assign special_send = res_s2.special_send;

endmodule
`default_nettype wire

// ===== design/alsc_in_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none
module alsc_in_reg (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire alsc_pkg::item_t in_item,
	input wire logic advance,
	output logic valid_s1,
	output alsc_pkg::item_t item_s1
);
	import alsc_pkg::*;

	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_item;
		end
	end

endmodule
`default_nettype wire

// ===== design/alsc_proc.sv =====
`timescale 1ns / 1ps
`default_nettype none
module alsc_proc (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_wr_en,
	input wire logic [5:0] cfg_wr_data,
	input wire logic valid_s1,
	input wire alsc_pkg::item_t item_s1,
	output logic advance,
	input wire logic out_stall,
	output logic out_valid_s2,
	output alsc_pkg::result_t res_s2
);
	import alsc_pkg::*;

	logic [5:0] device_id_q;
	frame_t frame_q;
	logic [5:0] line_num_q;
	logic [7:0] line_state_q;
	logic [15:0] block_q;
	logic [5:0] dim_q;
	logic [7:0] prev_pins_q;

	frame_t frame_d;
	logic [5:0] line_num_d;
	logic [7:0] line_state_d;
	logic [15:0] block_d;
	logic [5:0] dim_d;
	logic [7:0] prev_pins_d;
	result_t res_d;
	logic fire;

	assign advance = !out_valid_s2 || !out_stall;
	assign fire = valid_s1 && advance;

	always_comb begin
		logic [1:0] head;
		logic [5:0] body;
		logic [15:0] m;
		logic [7:0] lm;
		logic [7:0] pins;
		frame_d = frame_q;
		line_num_d = line_num_q;
		line_state_d = line_state_q;
		block_d = block_q;
		dim_d = dim_q;
		prev_pins_d = prev_pins_q;
		res_d = '0;
		head = item_s1.rx_byte[7:6];
		body = item_s1.rx_byte[5:0];
		m = line_mask(line_num_q);
		lm = m[7:0];
		pins = item_s1.switch_pins;
		res_d.reply_byte = REPLY_NONE;
		if (item_s1.cmd == ITEM_BYTE) begin
			if (head != HEAD_DEVICE && frame_q != FRM_IDLE) begin
				if (head == HEAD_LINE) begin
					line_num_d = body;
					frame_d = FRM_LINE;
				end else if (head == HEAD_COMMAND && frame_q == FRM_LINE) begin
					frame_d = FRM_IDLE;
					unique case (body)
						CMD_READ_LINE: begin
							res_d.reply_valid = 1'b1;
							res_d.reply_byte = |(line_state_q & lm) ? REPLY_YES : REPLY_NO;
						end
						CMD_LINE_ON: line_state_d = line_state_q | lm;
						CMD_LINE_OFF: line_state_d = line_state_q & ~lm;
						CMD_READ_BLOCK: begin
							res_d.reply_valid = 1'b1;
							res_d.reply_byte = |(block_q & m) ? REPLY_YES : REPLY_NO;
						end
						CMD_SET_BLOCK: block_d = block_q | m;
						CMD_CLR_BLOCK: block_d = block_q & ~m;
						CMD_SET_DIM: dim_d = line_num_q & DIM_MAX;
						CMD_READ_DIM: begin
							res_d.reply_valid = 1'b1;
							res_d.reply_byte = dim_q;
						end
						CMD_LINE_TOGGLE: line_state_d = line_state_q ^ lm;
						default: ;
					endcase
				end
			end else if (body == device_id_q) begin
				frame_d = FRM_ADDRESSED;
			end else begin
				frame_d = FRM_IDLE;
			end
		end else begin
			// lowering first, raising judged on the lowered level
			if (dim_d != 6'd0 && !block_q[BLOCK_DIM_DOWN]) begin
				res_d.dim_down_enable = 1'b1;
				if (!item_s1.dim_down_n) begin
					dim_d = dim_d - 6'd1;
				end
			end
			if (dim_d != DIM_MAX && !block_q[BLOCK_DIM_UP]) begin
				res_d.dim_up_enable = 1'b1;
				if (!item_s1.dim_up_n) begin
					dim_d = dim_d + 6'd1;
				end
			end
			for (int i = 0; i < 8; i++) begin
				if (i < SWITCH_COUNT && !block_q[i] && !pins[i] && prev_pins_q[i]) begin
					line_state_d[i] = ~line_state_q[i];
				end
			end
			res_d.special_send = !pins[SPECIAL_PIN] && prev_pins_q[SPECIAL_PIN]
				&& !block_q[BLOCK_SPECIAL];
			prev_pins_d = pins;
		end
		res_d.lines = line_state_d;
		res_d.dim_level = dim_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_id_q <= DEVICE_ID_RESET;
		end else if (cfg_wr_en) begin
			device_id_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= FRM_IDLE;
			line_num_q <= 6'd0;
			line_state_q <= 8'd0;
			block_q <= 16'd0;
			dim_q <= 6'd0;
			prev_pins_q <= 8'd0;
		end else if (fire) begin
			frame_q <= frame_d;
			line_num_q <= line_num_d;
			line_state_q <= line_state_d;
			block_q <= block_d;
			dim_q <= dim_d;
			prev_pins_q <= prev_pins_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res_d;
		end
	end

endmodule
`default_nettype wire

// ===== design/alsc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "addressed_light_switch_controller_core_assert.svh"
module alsc_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic reply_valid,
	input wire logic [5:0] reply_byte,
	input wire logic dim_down_enable,
	input wire logic dim_up_enable,
	input wire logic special_send
);

	// input side only backs up when the result register is full and held
	`ALSC_ASSERT_IMPLY(a_stall_cause, clk, arst_n, in_stall, out_valid && out_stall)

	// a held result stays offered
	`ALSC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)

	// no reply means a zero reply byte
	`ALSC_ASSERT_IMPLY(a_no_reply_zero, clk, arst_n, out_valid && !reply_valid,
		reply_byte == 6'd0)

	// tick indicators never come with a reply
	`ALSC_ASSERT_IMPLY(a_tick_no_reply, clk, arst_n,
		out_valid && (dim_down_enable || dim_up_enable || special_send), !reply_valid)

endmodule

bind addressed_light_switch_controller_core alsc_checker u_alsc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_stall(in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.reply_valid(reply_valid),
	.reply_byte(reply_byte),
	.dim_down_enable(dim_down_enable),
	.dim_up_enable(dim_up_enable),
	.special_send(special_send)
);
`default_nettype wire
